// ===== rtl/bfa_pkg.sv =====
// shared types and constants of the first-fit bitmap allocator
package bfa_pkg;

    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int BLK_W   = 3;
    localparam int DIRTY_W = 8;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 16;
    localparam int WIDX_W  = 11;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_LOAD    = 2'd2,
        OP_COLLECT = 2'd3
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [IDX_W-1:0]   bit_index;
        logic [WIDX_W-1:0]  word_index;
        logic [WORD_W-1:0]  word_data;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   allocated_index;
        logic               no_free;
        logic               bad_index;
        logic [DIRTY_W-1:0] dirty_mask;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_SCAN    = 3'd2,
        ST_FREE_WR = 3'd3,
        ST_RESP    = 3'd4
    } state_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic s_fire;
        op_t  opcode;
        logic free_bad;
        logic found;
        logic scan_done;
        logic clear_last;
        logic out_free;
    } stat_t;

    // state decode from the sequencer to the datapath
    typedef struct packed {
        logic s_ready;
        logic clearing;
        logic scanning;
        logic free_wr;
        logic resp;
    } ctrl_t;

endpackage

// ===== rtl/bfa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module bfa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfa_zero_find.sv =====
// finds the lowest clear bit of a bitmap word
module bfa_zero_find (
    input  logic [bfa_pkg::WORD_W-1:0] word,
    output logic                       found,
    output logic [bfa_pkg::BIT_W-1:0]  pos
);

    always_comb begin
        found = ~&word;
        pos   = '0;
        // highest first so the lowest clear bit wins
        for (int b = bfa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!word[b]) begin
                pos = bfa_pkg::BIT_W'(b);
            end
        end
    end

endmodule

// ===== rtl/bfa_ctrl.sv =====
// sequencer of the allocator: clear pass, scan, free read-modify-write, response
module bfa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  bfa_pkg::stat_t  stat,
    output bfa_pkg::ctrl_t  ctrl
);

    bfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfa_pkg::ST_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE: begin
                if (stat.s_fire) begin
                    case (stat.opcode)
                        bfa_pkg::OP_ALLOC: state_next = bfa_pkg::ST_SCAN;
                        bfa_pkg::OP_FREE: begin
                            state_next = stat.free_bad ? bfa_pkg::ST_RESP
                                                       : bfa_pkg::ST_FREE_WR;
                        end
                        default: state_next = bfa_pkg::ST_RESP;
                    endcase
                end
            end
            bfa_pkg::ST_SCAN: begin
                if (stat.found || stat.scan_done) begin
                    state_next = bfa_pkg::ST_RESP;
                end
            end
            bfa_pkg::ST_FREE_WR: state_next = bfa_pkg::ST_RESP;
            bfa_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            default: state_next = bfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            bfa_pkg::ST_CLEAR:   ctrl.clearing = 1'b1;
            bfa_pkg::ST_IDLE:    ctrl.s_ready  = 1'b1;
            bfa_pkg::ST_SCAN:    ctrl.scanning = 1'b1;
            bfa_pkg::ST_FREE_WR: ctrl.free_wr  = 1'b1;
            bfa_pkg::ST_RESP:    ctrl.resp     = 1'b1;
            default:             ctrl          = '0;
        endcase
    end

endmodule

// ===== rtl/bitmap_first_free_allocator_unit.sv =====
// top level of the first-fit bitmap allocator
// allocate: scan from word 0 for the first clear bit, over n words (at most
//   blocks_in_use * BLOCK_BYTES / 4), one bitmap word per cycle through the ram read port
// free: read, modify-write, response; a rejected index skips the modify-write
// load and collect: no scan; one transaction in process, its result may wait in the output register
// after reset a clearing pass writes MAX_MAP_BLOCKS * BLOCK_BYTES / 4 words of zero,
//   one per cycle, during which no input transaction is taken (config writes still are)
module bitmap_first_free_allocator_unit #(
    parameter int BLOCK_BYTES    = 1024,
    parameter int MAX_MAP_BLOCKS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bfa_pkg::req_t               s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output bfa_pkg::rsp_t               m_data,
    // blocks_in_use write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]   cfg_data
);

    // bitmap geometry
    localparam int WPB   = BLOCK_BYTES / 4;
    localparam int TOTAL = MAX_MAP_BLOCKS * WPB;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    // common compare width, covers the load address and the free word address
    localparam int XW    = (AW + 1 > bfa_pkg::WIDX_W) ? AW + 1 : bfa_pkg::WIDX_W;

    bfa_pkg::ctrl_t ctrl;
    bfa_pkg::stat_t stat;

    // control state
    logic [bfa_pkg::CFG_W-1:0]   blocks_reg, blocks_next;
    logic [bfa_pkg::DIRTY_W-1:0] dirty_reg, dirty_next;
    logic [XW-1:0]               addr_reg, addr_next;
    logic                        pend_reg, pend_next;
    logic                        m_valid_reg, m_valid_next;

    // payload
    bfa_pkg::req_t req_reg, req_next;
    logic [XW-1:0] pend_addr_reg;
    bfa_pkg::rsp_t res_reg, res_next;
    bfa_pkg::rsp_t m_data_reg, m_data_next;

    logic                        s_fire;
    logic [bfa_pkg::CFG_W-1:0]   used_blocks;
    logic [XW-1:0]               scan_end;
    logic [XW-1:0]               in_free_addr;
    logic [XW-1:0]               req_free_addr;
    logic [XW-1:0]               ld_addr;
    logic                        free_bad;
    logic                        load_ok;
    logic                        scan_issue;
    logic                        found;
    logic                        scan_done;
    logic                        clear_last;
    logic                        out_free;
    logic [XW-1:0]               blk_addr;
    logic [bfa_pkg::BLK_W-1:0]   blk;
    logic [bfa_pkg::BIT_W-1:0]   bit_sel;
    logic [bfa_pkg::WORD_W-1:0]  bit_onehot;
    logic [XW+bfa_pkg::BIT_W-1:0] global_idx;

    // ram and word checker
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [bfa_pkg::WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [bfa_pkg::WORD_W-1:0]  ram_rdata;
    logic                        zf_found;
    logic [bfa_pkg::BIT_W-1:0]   zf_pos;

    bfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    bfa_ram #(
        .WIDTH (bfa_pkg::WORD_W),
        .DEPTH (TOTAL),
        .ADDR_W(AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_zero_find u_zero_find (
        .word  (ram_rdata),
        .found (zf_found),
        .pos   (zf_pos)
    );

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = ctrl.s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // block count saturates at the number of map blocks built
    assign used_blocks = (blocks_reg > bfa_pkg::CFG_W'(MAX_MAP_BLOCKS))
                       ? bfa_pkg::CFG_W'(MAX_MAP_BLOCKS) : blocks_reg;
    // first word past the searched region
    assign scan_end = XW'(used_blocks) * XW'(WPB);

    // a global bit number is word address * 32 + bit, so the word address is a shift
    assign in_free_addr  = XW'(s_data.bit_index[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W]);
    assign req_free_addr = XW'(req_reg.bit_index[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W]);
    assign ld_addr       = XW'(s_data.word_index);
    assign free_bad      = in_free_addr >= scan_end;
    assign load_ok       = ld_addr < XW'(TOTAL);

    // scan pipeline: issue one read per cycle, check the word read the cycle before
    assign scan_issue = ctrl.scanning && (addr_reg < scan_end);
    assign found      = ctrl.scanning && pend_reg && zf_found;
    assign scan_done  = ctrl.scanning && (addr_reg == scan_end) && (!pend_reg || !zf_found);
    assign clear_last = addr_reg == XW'(TOTAL - 1);

    // block of a word address, compared against constant block boundaries
    assign blk_addr = ctrl.scanning ? pend_addr_reg : req_free_addr;
    always_comb begin
        blk = '0;
        for (int k = 1; k < MAX_MAP_BLOCKS; k++) begin
            if (blk_addr >= XW'(k * WPB)) begin
                blk = bfa_pkg::BLK_W'(k);
            end
        end
    end

    assign bit_sel    = ctrl.scanning ? zf_pos : req_reg.bit_index[bfa_pkg::BIT_W-1:0];
    assign bit_onehot = bfa_pkg::WORD_W'(1) << bit_sel;
    assign global_idx = {pend_addr_reg, zf_pos};

    // read port: scan address while scanning, free word address at accept
    assign ram_raddr = ctrl.scanning ? addr_reg[AW-1:0] : in_free_addr[AW-1:0];

    // write port: clear pass, load, allocate set or free clear
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg[AW-1:0];
        ram_wdata = '0;
        if (ctrl.clearing) begin
            ram_we = 1'b1;
        end else if (s_fire && s_data.opcode == bfa_pkg::OP_LOAD && load_ok) begin
            ram_we    = 1'b1;
            ram_waddr = ld_addr[AW-1:0];
            ram_wdata = s_data.word_data;
        end else if (found) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg[AW-1:0];
            ram_wdata = ram_rdata | bit_onehot;
        end else if (ctrl.free_wr) begin
            ram_we    = 1'b1;
            ram_waddr = req_free_addr[AW-1:0];
            ram_wdata = ram_rdata & ~bit_onehot;
        end
    end

    // status to the sequencer
    always_comb begin
        stat            = '0;
        stat.s_fire     = s_fire;
        stat.opcode     = s_data.opcode;
        stat.free_bad   = free_bad;
        stat.found      = found;
        stat.scan_done  = scan_done;
        stat.clear_last = clear_last;
        stat.out_free   = out_free;
    end

    // next values
    always_comb begin
        blocks_next  = blocks_reg;
        dirty_next   = dirty_reg;
        addr_next    = addr_reg;
        pend_next    = scan_issue;
        req_next     = req_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            blocks_next = cfg_data;
        end

        // shared address counter for the clear pass and the scan
        if (ctrl.clearing) begin
            addr_next = clear_last ? '0 : addr_reg + XW'(1);
        end else if (s_fire) begin
            addr_next = '0;
        end else if (scan_issue) begin
            addr_next = addr_reg + XW'(1);
        end

        if (s_fire) begin
            req_next            = s_data;
            res_next            = '0;
            res_next.bad_index  = (s_data.opcode == bfa_pkg::OP_FREE) && free_bad;
            if (s_data.opcode == bfa_pkg::OP_COLLECT) begin
                res_next.dirty_mask = dirty_reg;
                dirty_next          = '0;
            end
        end

        if (found) begin
            res_next                 = '0;
            res_next.allocated_index = global_idx[bfa_pkg::IDX_W-1:0];
            dirty_next               = dirty_reg | (bfa_pkg::DIRTY_W'(1) << blk);
        end else if (scan_done) begin
            res_next         = '0;
            res_next.no_free = 1'b1;
        end

        if (ctrl.free_wr) begin
            dirty_next = dirty_reg | (bfa_pkg::DIRTY_W'(1) << blk);
        end

        // output register, refilled from the response stage when free
        if (ctrl.resp && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_reg  <= bfa_pkg::CFG_W'(1);
            dirty_reg   <= '0;
            addr_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            blocks_reg  <= blocks_next;
            dirty_reg   <= dirty_next;
            addr_reg    <= addr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        pend_addr_reg <= addr_reg;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an accepted transaction always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    // a failed allocation carries no bit number
    a_no_free_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.no_free) |-> (m_data.allocated_index == '0 && !m_data.bad_index))
        else $error("no_free result with other fields set");

    // dirty flags only accumulate between collects
    a_dirty_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(s_fire && s_data.opcode == bfa_pkg::OP_COLLECT))
        |-> ((dirty_reg & $past(dirty_reg)) == $past(dirty_reg)))
        else $error("dirty flag lost without collect");

    // the clearing pass runs only right after reset
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.clearing |=> !ctrl.clearing)
        else $error("clearing pass restarted");

endmodule

// ===== tb/bitmap_alloc_checker.sv =====
// checker that predicts and compares the allocator results
`timescale 1ns / 100ps

module bitmap_alloc_checker #(
    parameter int BLOCK_BYTES    = 1024,
    parameter int MAX_MAP_BLOCKS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  bfa_pkg::req_t               s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  bfa_pkg::rsp_t               m_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]   cfg_data,
    output int                          fail_count,
    output int                          outstanding
);

    localparam int WORDS_PER_BLK = BLOCK_BYTES / 4;
    localparam int BITS_PER_BLK  = WORDS_PER_BLK * bfa_pkg::WORD_W;
    localparam int MAP_WORDS     = MAX_MAP_BLOCKS * WORDS_PER_BLK;

    logic [bfa_pkg::WORD_W-1:0]  map_word [MAP_WORDS];
    logic [bfa_pkg::DIRTY_W-1:0] dirty_blocks;
    logic [bfa_pkg::CFG_W-1:0]   blocks_cfg;
    bfa_pkg::rsp_t               pending_responses[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // applies one request to the shadow bitmap and returns its response
    function automatic bfa_pkg::rsp_t allocator_response(input bfa_pkg::req_t rq);
        bfa_pkg::rsp_t rs;
        int unsigned   used;
        int unsigned   blk;
        int unsigned   rem;
        int unsigned   addr;
        bit            found;
        rs    = '0;
        found = 1'b0;
        used  = (blocks_cfg > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : blocks_cfg;
        case (rq.opcode)
            bfa_pkg::OP_ALLOC: begin
                for (int b = 0; b < used && !found; b++) begin
                    for (int w = 0; w < WORDS_PER_BLK && !found; w++) begin
                        addr = b * WORDS_PER_BLK + w;
                        for (int k = 0; k < bfa_pkg::WORD_W && !found; k++) begin
                            if (!map_word[addr][k]) begin
                                map_word[addr][k]  = 1'b1;
                                dirty_blocks[b]    = 1'b1;
                                rs.allocated_index = bfa_pkg::IDX_W'(b * BITS_PER_BLK
                                                     + w * bfa_pkg::WORD_W + k);
                                found              = 1'b1;
                            end
                        end
                    end
                end
                rs.no_free = !found;
            end
            bfa_pkg::OP_FREE: begin
                blk = rq.bit_index / BITS_PER_BLK;
                if (blk >= used) begin
                    rs.bad_index = 1'b1;
                end else begin
                    rem = rq.bit_index % BITS_PER_BLK;
                    map_word[blk * WORDS_PER_BLK + rem / bfa_pkg::WORD_W]
                            [rem % bfa_pkg::WORD_W] = 1'b0;
                    dirty_blocks[blk] = 1'b1;
                end
            end
            bfa_pkg::OP_LOAD: begin
                if (rq.word_index < MAP_WORDS)
                    map_word[rq.word_index] = rq.word_data;
            end
            bfa_pkg::OP_COLLECT: begin
                rs.dirty_mask = dirty_blocks;
                dirty_blocks  = '0;
            end
        endcase
        return rs;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        bfa_pkg::rsp_t want;
        if (!aresetn) begin
            foreach (map_word[i]) map_word[i] = '0;
            dirty_blocks = '0;
            blocks_cfg   = 1;
            pending_responses.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_responses.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    want = pending_responses.pop_front();
                    compare_field("allocated_index", 32'(want.allocated_index),
                                  32'(m_data.allocated_index));
                    compare_field("no_free", 32'(want.no_free), 32'(m_data.no_free));
                    compare_field("bad_index", 32'(want.bad_index),
                                  32'(m_data.bad_index));
                    compare_field("dirty_mask", 32'(want.dirty_mask),
                                  32'(m_data.dirty_mask));
                end
            end
            if (s_valid && s_ready)
                pending_responses.push_back(allocator_response(s_data));
            if (cfg_valid && cfg_ready)
                blocks_cfg = cfg_data;
        end
        outstanding <= pending_responses.size();
    end

endmodule

// ===== tb/bitmap_first_free_allocator_unit_tb.sv =====
// testbench top of the first-fit bitmap allocator: stimulus and verdict
`timescale 1ns / 100ps

module bitmap_first_free_allocator_unit_tb;

    localparam int BLOCK_BYTES    = 1024;
    localparam int MAX_MAP_BLOCKS = 8;
    localparam int WORDS_PER_BLK  = BLOCK_BYTES / 4;
    localparam int BITS_PER_BLK   = WORDS_PER_BLK * bfa_pkg::WORD_W;
    localparam int FILL_WORDS     = 32;
    localparam int ITEMS_PER_HALF = 28;
    localparam int DRAIN_CYCLES   = 16;
    // worst case: ~290 transactions, each a full 2048-word scan plus stalls, then margin
    localparam int unsigned RUN_LIMIT = 3_000_000;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    bfa_pkg::req_t              s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    bfa_pkg::rsp_t              m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [bfa_pkg::CFG_W-1:0]  cfg_data  = '0;

    int                fail_count;
    int                outstanding;
    int unsigned       cycle_count = 0;
    int unsigned       gap_pct     = 0;
    int unsigned       stall_pct   = 0;
    // the block count last written, so stimulus can aim at blocks in use
    int unsigned       cur_blocks  = 1;

    // per-phase block counts: the extremes plus a few in between
    logic [bfa_pkg::CFG_W-1:0] phase_blocks [8] =
        '{4'd1, 4'd8, 4'd2, 4'd15, 4'd3, 4'd8, 4'd5, 4'd12};

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bitmap_first_free_allocator_unit #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .MAX_MAP_BLOCKS (MAX_MAP_BLOCKS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bitmap_alloc_checker #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .MAX_MAP_BLOCKS (MAX_MAP_BLOCKS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog against a hung handshake or a lost result
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request transaction, with an optional idle gap in front of it
    task automatic issue(input bfa_pkg::op_t op, input logic [bfa_pkg::IDX_W-1:0] bit_idx,
                         input logic [bfa_pkg::WIDX_W-1:0] word_idx,
                         input logic [bfa_pkg::WORD_W-1:0] data);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_data.opcode     <= op;
        s_data.bit_index  <= bit_idx;
        s_data.word_index <= word_idx;
        s_data.word_data  <= data;
        s_valid           <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // block count write, only ever while the block is idle
    task automatic set_blocks(input logic [bfa_pkg::CFG_W-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cur_blocks  = (value > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : value;
    endtask

    // short hand-picked sequence over the corner cases
    task automatic run_directed();
        // reset block count of one, empty dirty mask
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        issue(bfa_pkg::OP_FREE, 0, 0, 0);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        // free beyond the single block in use, and the highest index
        issue(bfa_pkg::OP_FREE, bfa_pkg::IDX_W'(BITS_PER_BLK), 0, 0);
        issue(bfa_pkg::OP_FREE, '1, 0, 0);
        // full first word, then a word with only its top bit clear
        issue(bfa_pkg::OP_LOAD, 0, 0, '1);
        issue(bfa_pkg::OP_LOAD, 0, 1, 32'h7fff_ffff);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        // load into the last word, outside the blocks in use
        issue(bfa_pkg::OP_LOAD, 0, '1, 32'ha5a5_5a5a);
        issue(bfa_pkg::OP_FREE, bfa_pkg::IDX_W'(BITS_PER_BLK - 1), 0, 0);
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
        // zero blocks: nothing to allocate, every free rejected
        set_blocks(0);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        issue(bfa_pkg::OP_FREE, 0, 0, 0);
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
        // count above the maximum acts as the maximum
        set_blocks('1);
        issue(bfa_pkg::OP_FREE, '1, 0, 0);
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        issue(bfa_pkg::OP_LOAD, 0, bfa_pkg::WIDX_W'(WORDS_PER_BLK - 1), 0);
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
        set_blocks(bfa_pkg::CFG_W'(MAX_MAP_BLOCKS));
        issue(bfa_pkg::OP_ALLOC, 0, 0, 0);
        issue(bfa_pkg::OP_FREE, 16'h8000, 0, 0);
        issue(bfa_pkg::OP_COLLECT, 0, 0, 0);
    endtask

    // fill the start of the first block so allocation must scan past it
    task automatic fill_first_block();
        int unsigned                hole_word;
        logic [bfa_pkg::WORD_W-1:0] data;
        set_blocks(1);
        // about half the time one word keeps a single clear bit
        hole_word = ($urandom_range(1) != 0) ? $urandom_range(FILL_WORDS - 1)
                                             : FILL_WORDS;
        for (int w = 0; w < FILL_WORDS; w++) begin
            data = '1;
            if (w == hole_word)
                data[bfa_pkg::BIT_W'($urandom_range(bfa_pkg::WORD_W - 1))] = 1'b0;
            issue(bfa_pkg::OP_LOAD, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'(w), data);
        end
        issue(bfa_pkg::OP_ALLOC, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
        issue(bfa_pkg::OP_ALLOC, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
        issue(bfa_pkg::OP_FREE, bfa_pkg::IDX_W'($urandom_range(FILL_WORDS * bfa_pkg::WORD_W - 1)),
              bfa_pkg::WIDX_W'($urandom), $urandom);
        issue(bfa_pkg::OP_ALLOC, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
        issue(bfa_pkg::OP_COLLECT, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
        // next block opens up behind the first one
        set_blocks(2);
        issue(bfa_pkg::OP_ALLOC, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
        issue(bfa_pkg::OP_COLLECT, bfa_pkg::IDX_W'($urandom), bfa_pkg::WIDX_W'($urandom),
              $urandom);
    endtask

    // one random transaction, mostly aimed at the blocks in use
    task automatic random_item();
        int unsigned                 pick;
        int unsigned                 aim;
        logic [bfa_pkg::IDX_W-1:0]   bit_idx;
        logic [bfa_pkg::WIDX_W-1:0]  word_idx;
        logic [bfa_pkg::WORD_W-1:0]  data;
        bit_idx  = bfa_pkg::IDX_W'($urandom);
        word_idx = bfa_pkg::WIDX_W'($urandom);
        data     = $urandom;
        pick     = $urandom_range(99);
        aim      = $urandom_range(9);
        if (pick < 35) begin
            issue(bfa_pkg::OP_ALLOC, bit_idx, word_idx, data);
        end else if (pick < 65) begin
            // low bits of a block are where allocations land
            if (cur_blocks != 0 && aim < 5)
                bit_idx = bfa_pkg::IDX_W'($urandom_range(cur_blocks - 1) * BITS_PER_BLK
                                          + $urandom_range(95));
            else if (cur_blocks != 0 && aim < 8)
                bit_idx = bfa_pkg::IDX_W'($urandom_range(cur_blocks * BITS_PER_BLK - 1));
            issue(bfa_pkg::OP_FREE, bit_idx, word_idx, data);
        end else if (pick < 85) begin
            if (cur_blocks != 0 && aim < 5)
                word_idx = bfa_pkg::WIDX_W'($urandom_range(cur_blocks - 1) * WORDS_PER_BLK
                                            + $urandom_range(3));
            if (aim % 3 == 0)
                data = '1;
            else if (aim == 1)
                data = '0;
            issue(bfa_pkg::OP_LOAD, bit_idx, word_idx, data);
        end else begin
            issue(bfa_pkg::OP_COLLECT, bit_idx, word_idx, data);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        fill_first_block();

        // idle phases: none, sender only, receiver only, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase
            for (int half = 0; half < 2; half++) begin
                set_blocks(phase_blocks[phase * 2 + half]);
                repeat (ITEMS_PER_HALF) random_item();
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        drain();
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
